// ===== rtl/core/mbr_partition_map_translate_unit_defines.svh =====
// assertion macros for the mbr partition map translate unit
`ifndef MBR_PARTITION_MAP_TRANSLATE_UNIT_DEFINES_SVH
`define MBR_PARTITION_MAP_TRANSLATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBRPT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// delayed implication, disabled during reset
`define MBRPT_ASSERT_LATER(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

// ===== rtl/core/mbrpt_pkg.sv =====
// shared types and constants of the mbr partition map translate unit
`timescale 1ns / 1ps

package mbrpt_pkg;

   // table geometry
   localparam int SLOT_COUNT   = 4;
   localparam int SLOT_W       = 2;
   localparam int SECTOR_BYTES = 512;
   localparam int POS_W        = 9;

   // sector layout
   localparam logic [POS_W-1:0] TABLE_OFFSET = 9'd446;
   localparam logic [POS_W-1:0] TABLE_END    = 9'd510;
   localparam logic [POS_W-1:0] SIG_OFFSET   = 9'd510;
   localparam logic [POS_W-1:0] LAST_BYTE    = 9'd511;

   // entry field offsets inside a 16-byte entry
   localparam logic [3:0] ENTRY_TYPE_OFF = 4'd4;

   // magic values
   localparam logic [7:0] SIG_FIRST  = 8'h55;
   localparam logic [7:0] SIG_SECOND = 8'hAA;
   localparam logic [7:0] TYPE_CHS   = 8'h0B;
   localparam logic [7:0] TYPE_LBA   = 8'h0C;

   // request opcodes
   localparam logic [1:0] OP_SECTOR = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_WRITE  = 2'd2;

   // answer kinds
   localparam logic KIND_SCAN   = 1'b0;
   localparam logic KIND_ACCESS = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [31:0] start;
      logic [31:0] length;
   } slot_entry_type;

   typedef struct packed {
      logic                  done;
      logic                  ok;
      logic [SLOT_COUNT-1:0] mask;
   } scan_status_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [7:0]        sector_byte;
      logic [SLOT_W-1:0] partition_index;
      logic [31:0]       block_address;
      logic [31:0]       transfer_count;
   } request_type;

endpackage

// ===== rtl/core/mbrpt_sector_scan.sv =====
// sector byte capture, signature check and partition slot table
`timescale 1ns / 1ps

module mbrpt_sector_scan (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  byte_en,
   input  logic [7:0]                                            byte_value,
   output mbrpt_pkg::slot_entry_type [mbrpt_pkg::SLOT_COUNT-1:0] slots,
   output mbrpt_pkg::scan_status_type                            status
);

   logic [mbrpt_pkg::POS_W-1:0]                   pos_ff;
   logic [mbrpt_pkg::POS_W-1:0]                   pos_in;
   logic                                          sig_first_ok_ff;
   logic [mbrpt_pkg::SLOT_COUNT-1:0][7:0]         cap_type_ff;
   logic [mbrpt_pkg::SLOT_COUNT-1:0][3:0][7:0]    cap_start_ff;
   logic [mbrpt_pkg::SLOT_COUNT-1:0][3:0][7:0]    cap_length_ff;
   logic [mbrpt_pkg::SLOT_COUNT-1:0]              slot_valid_ff;
   logic [mbrpt_pkg::SLOT_COUNT-1:0][31:0]        slot_start_ff;
   logic [mbrpt_pkg::SLOT_COUNT-1:0][31:0]        slot_length_ff;

   logic [mbrpt_pkg::POS_W-1:0]   rel;
   logic [mbrpt_pkg::SLOT_W-1:0]  entry_sel;
   logic [3:0]                    entry_off;
   logic                          in_table;
   logic                          last_byte;
   logic                          sig_ok;
   logic [mbrpt_pkg::SLOT_COUNT-1:0] commit;

   // position decode inside the partition table area
   assign rel       = pos_ff - mbrpt_pkg::TABLE_OFFSET;
   assign entry_sel = rel[5:4];
   assign entry_off = rel[3:0];
   assign in_table  = (pos_ff >= mbrpt_pkg::TABLE_OFFSET) && (pos_ff < mbrpt_pkg::TABLE_END);
   assign last_byte = (pos_ff == mbrpt_pkg::LAST_BYTE);
   assign pos_in    = last_byte ? '0 : pos_ff + 1'b1;

   // signature and per-slot commit qualification
   assign sig_ok = sig_first_ok_ff && (byte_value == mbrpt_pkg::SIG_SECOND);

   always_comb begin
      for (int i = 0; i < mbrpt_pkg::SLOT_COUNT; i++) begin
         commit[i] = sig_ok
                  && ((cap_type_ff[i] == mbrpt_pkg::TYPE_CHS)
                   || (cap_type_ff[i] == mbrpt_pkg::TYPE_LBA))
                  && (cap_length_ff[i] != '0);
      end
   end

   // scan status for the last sector byte
   assign status.done = byte_en && last_byte;
   assign status.ok   = sig_ok;
   assign status.mask = commit;

   // control state: position, signature flag, slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         sig_first_ok_ff <= 1'b0;
         slot_valid_ff   <= '0;
      end else if (byte_en) begin
         pos_ff <= pos_in;
         if (pos_ff == mbrpt_pkg::SIG_OFFSET) begin
            sig_first_ok_ff <= (byte_value == mbrpt_pkg::SIG_FIRST);
         end
         if (last_byte) begin
            slot_valid_ff <= slot_valid_ff | commit;
         end
      end
   end

   // entry capture and slot payload
   always_ff @(posedge clock) begin
      if (byte_en && in_table) begin
         if (entry_off == mbrpt_pkg::ENTRY_TYPE_OFF) begin
            cap_type_ff[entry_sel] <= byte_value;
         end else if (entry_off[3:2] == 2'b10) begin
            cap_start_ff[entry_sel][entry_off[1:0]] <= byte_value;
         end else if (entry_off[3:2] == 2'b11) begin
            cap_length_ff[entry_sel][entry_off[1:0]] <= byte_value;
         end
      end
      if (byte_en && last_byte) begin
         for (int i = 0; i < mbrpt_pkg::SLOT_COUNT; i++) begin
            if (commit[i]) begin
               slot_start_ff[i]  <= cap_start_ff[i];
               slot_length_ff[i] <= cap_length_ff[i];
            end
         end
      end
   end

   // slot table view
   always_comb begin
      for (int i = 0; i < mbrpt_pkg::SLOT_COUNT; i++) begin
         slots[i].valid  = slot_valid_ff[i];
         slots[i].start  = slot_start_ff[i];
         slots[i].length = slot_length_ff[i];
      end
   end

endmodule

// ===== rtl/core/mbrpt_access_check.sv =====
// bounds check and rebase of a read or write request against one slot
`timescale 1ns / 1ps

module mbrpt_access_check (
   input  mbrpt_pkg::slot_entry_type [mbrpt_pkg::SLOT_COUNT-1:0] slots,
   input  logic [mbrpt_pkg::SLOT_W-1:0]                          partition_index,
   input  logic [31:0]                                           block_address,
   input  logic [31:0]                                           transfer_count,
   output logic                                                  accepted,
   output logic [31:0]                                           parent_address
);

   mbrpt_pkg::slot_entry_type entry;
   logic [31:0]               remaining;

   // slot select and bounds
   assign entry     = slots[partition_index];
   assign remaining = entry.length - block_address;
   assign accepted  = entry.valid
                   && (transfer_count != '0)
                   && (block_address < entry.length)
                   && (transfer_count <= remaining);

   // rebase, wraps modulo 2^32
   assign parent_address = entry.start + block_address;

endmodule

// ===== rtl/core/mbr_partition_map_translate_unit.sv =====
// top level of the mbr partition map translate unit
// a taken request passes the input register and then the result register before rsp_valid
// throughput: one request per cycle, busy stays low; sector bytes and accesses interleave
// a sector byte other than the last, or opcode 3, gives no answer
// reset: synchronous; clears byte position, signature flag, slot valid bits and valid flags
// the receiver cannot stall the answer strobe
`timescale 1ns / 1ps
`include "mbr_partition_map_translate_unit_defines.svh"

module mbr_partition_map_translate_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_sector_byte,
   input  logic [1:0]  req_partition_index,
   input  logic [31:0] req_block_address,
   input  logic [31:0] req_transfer_count,
   output logic        rsp_valid,
   output logic        rsp_answer_kind,
   output logic        rsp_accepted,
   output logic [31:0] rsp_parent_address,
   output logic [31:0] rsp_granted_count,
   output logic        rsp_direction_write,
   output logic [3:0]  rsp_registered_mask
);

   logic                   req_valid_ff;
   mbrpt_pkg::request_type req_ff;
   mbrpt_pkg::request_type req_in;

   mbrpt_pkg::slot_entry_type [mbrpt_pkg::SLOT_COUNT-1:0] slots;
   mbrpt_pkg::scan_status_type                            scan_status;

   logic        is_sector;
   logic        is_access;
   logic        acc_ok;
   logic [31:0] acc_parent;

   logic        rsp_valid_ff,  rsp_valid_in;
   logic        rsp_kind_ff,   rsp_kind_in;
   logic        rsp_ok_ff,     rsp_ok_in;
   logic [31:0] rsp_parent_ff, rsp_parent_in;
   logic [31:0] rsp_count_ff,  rsp_count_in;
   logic        rsp_write_ff,  rsp_write_in;
   logic [3:0]  rsp_mask_ff,   rsp_mask_in;

   // every cycle can take a request
   assign busy = 1'b0;

   // input register
   assign req_in.opcode          = req_opcode;
   assign req_in.sector_byte     = req_sector_byte;
   assign req_in.partition_index = req_partition_index;
   assign req_in.block_address   = req_block_address;
   assign req_in.transfer_count  = req_transfer_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_in;
      end
   end

   // opcode decode
   assign is_sector = req_valid_ff && (req_ff.opcode == mbrpt_pkg::OP_SECTOR);
   assign is_access = req_valid_ff && ((req_ff.opcode == mbrpt_pkg::OP_READ)
                                    || (req_ff.opcode == mbrpt_pkg::OP_WRITE));

   mbrpt_sector_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (is_sector),
      .byte_value (req_ff.sector_byte),
      .slots      (slots),
      .status     (scan_status)
   );

   mbrpt_access_check u_access (
      .slots           (slots),
      .partition_index (req_ff.partition_index),
      .block_address   (req_ff.block_address),
      .transfer_count  (req_ff.transfer_count),
      .accepted        (acc_ok),
      .parent_address  (acc_parent)
   );

   // answer select
   always_comb begin
      rsp_valid_in  = scan_status.done || is_access;
      rsp_kind_in   = mbrpt_pkg::KIND_SCAN;
      rsp_ok_in     = 1'b0;
      rsp_parent_in = '0;
      rsp_count_in  = '0;
      rsp_write_in  = 1'b0;
      rsp_mask_in   = '0;
      if (scan_status.done) begin
         rsp_ok_in   = scan_status.ok;
         rsp_mask_in = scan_status.mask;
      end else if (is_access) begin
         rsp_kind_in  = mbrpt_pkg::KIND_ACCESS;
         rsp_ok_in    = acc_ok;
         rsp_write_in = (req_ff.opcode == mbrpt_pkg::OP_WRITE);
         if (acc_ok) begin
            rsp_parent_in = acc_parent;
            rsp_count_in  = req_ff.transfer_count;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_write_ff  <= rsp_write_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_answer_kind     = rsp_kind_ff;
   assign rsp_accepted        = rsp_ok_ff;
   assign rsp_parent_address  = rsp_parent_ff;
   assign rsp_granted_count   = rsp_count_ff;
   assign rsp_direction_write = rsp_write_ff;
   assign rsp_registered_mask = rsp_mask_ff;

   // checks
   `MBRPT_ASSERT_NOW(a_reject_zero, clock, reset,
      rsp_valid && (rsp_answer_kind == mbrpt_pkg::KIND_ACCESS) && !rsp_accepted,
      (rsp_parent_address == '0) && (rsp_granted_count == '0),
      "rejected access carries nonzero address or count")
   `MBRPT_ASSERT_NOW(a_scan_clean, clock, reset,
      rsp_valid && (rsp_answer_kind == mbrpt_pkg::KIND_SCAN),
      (rsp_parent_address == '0) && (rsp_granted_count == '0) && !rsp_direction_write,
      "scan status carries access fields")
   `MBRPT_ASSERT_NOW(a_mask_needs_sig, clock, reset,
      rsp_valid && (rsp_answer_kind == mbrpt_pkg::KIND_SCAN) && (rsp_registered_mask != '0),
      rsp_accepted,
      "slots committed without valid signature")
   `MBRPT_ASSERT_LATER(a_read_answered, clock, reset,
      start && !busy && (req_opcode == mbrpt_pkg::OP_READ),
      rsp_valid && (rsp_answer_kind == mbrpt_pkg::KIND_ACCESS) && !rsp_direction_write
         && (rsp_registered_mask == '0),
      "read request not answered as a read")

endmodule

// ===== bench/tb_mbr_partition_map_translate_unit.sv =====
// self-checking testbench for the mbr partition map translate unit
`timescale 1ns / 1ps

module tb_mbr_partition_map_translate_unit;

   // opcode that the block drops without an answer
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic        kind;
      logic        accepted;
      logic [31:0] parent_address;
      logic [31:0] granted_count;
      logic        direction_write;
      logic [3:0]  registered_mask;
   } answer_fields_type;

   // partition table predictor plus the queue of answers still owed by the block
   class scoreboard_type;
      mbrpt_pkg::slot_entry_type   slots [mbrpt_pkg::SLOT_COUNT];
      logic [mbrpt_pkg::POS_W-1:0] next_pos;
      logic [7:0]                  cap_type [mbrpt_pkg::SLOT_COUNT];
      logic [31:0]                 cap_start [mbrpt_pkg::SLOT_COUNT];
      logic [31:0]                 cap_length [mbrpt_pkg::SLOT_COUNT];
      logic                        sig_first_ok;
      answer_fields_type           expected_answers [$];
      int failures, scans, good_scans, accesses, granted;

      function new();
         next_pos     = '0;
         sig_first_ok = 1'b0;
         foreach (slots[i]) begin
            slots[i]      = '0;
            cap_type[i]   = '0;
            cap_start[i]  = '0;
            cap_length[i] = '0;
         end
         failures   = 0;
         scans      = 0;
         good_scans = 0;
         accesses   = 0;
         granted    = 0;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      // predict the answer, if any, of one accepted request
      function void note_request(logic [1:0] op, logic [7:0] data, logic [1:0] idx,
                                 logic [31:0] lba, logic [31:0] cnt);
         answer_fields_type           ans;
         logic [mbrpt_pkg::POS_W-1:0] rel;
         logic [1:0]                  entry;
         logic [3:0]                  off;
         logic                        ok;
         logic [3:0]                  mask;
         ans = '0;
         if (op == mbrpt_pkg::OP_SECTOR) begin
            // capture type, start and length lanes of the four entries
            if (next_pos >= mbrpt_pkg::TABLE_OFFSET && next_pos < mbrpt_pkg::TABLE_END) begin
               rel   = next_pos - mbrpt_pkg::TABLE_OFFSET;
               entry = rel[5:4];
               off   = rel[3:0];
               if (off == mbrpt_pkg::ENTRY_TYPE_OFF)
                  cap_type[entry] = data;
               else if (off >= 4'd8 && off < 4'd12)
                  cap_start[entry][{off[1:0], 3'b000} +: 8] = data;
               else if (off >= 4'd12)
                  cap_length[entry][{off[1:0], 3'b000} +: 8] = data;
            end
            if (next_pos == mbrpt_pkg::SIG_OFFSET)
               sig_first_ok = (data == mbrpt_pkg::SIG_FIRST);
            // last byte: signature check and commit of qualifying entries
            if (next_pos == mbrpt_pkg::LAST_BYTE) begin
               ok   = sig_first_ok && (data == mbrpt_pkg::SIG_SECOND);
               mask = '0;
               if (ok) begin
                  for (int i = 0; i < mbrpt_pkg::SLOT_COUNT; i++) begin
                     if ((cap_type[i] == mbrpt_pkg::TYPE_CHS ||
                          cap_type[i] == mbrpt_pkg::TYPE_LBA) &&
                         cap_length[i] != 32'd0) begin
                        slots[i].valid  = 1'b1;
                        slots[i].start  = cap_start[i];
                        slots[i].length = cap_length[i];
                        mask[i]         = 1'b1;
                     end
                  end
               end
               ans.kind            = mbrpt_pkg::KIND_SCAN;
               ans.accepted        = ok;
               ans.registered_mask = mask;
               expected_answers.push_back(ans);
               scans++;
               if (ok) good_scans++;
            end
            next_pos = next_pos + 1'b1;
         end else if (op == mbrpt_pkg::OP_READ || op == mbrpt_pkg::OP_WRITE) begin
            // bounds check and rebase onto the parent address
            ok = slots[idx].valid && cnt != 32'd0 && lba < slots[idx].length &&
                 cnt <= slots[idx].length - lba;
            ans.kind            = mbrpt_pkg::KIND_ACCESS;
            ans.accepted        = ok;
            ans.direction_write = (op == mbrpt_pkg::OP_WRITE);
            if (ok) begin
               ans.parent_address = slots[idx].start + lba;
               ans.granted_count  = cnt;
               granted++;
            end
            expected_answers.push_back(ans);
            accesses++;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      // compare one answer against the oldest prediction
      function void check_answer(answer_fields_type got);
         answer_fields_type want;
         if (expected_answers.size() == 0) begin
            $error("answer with no request outstanding: kind %0b accepted %0b",
                   got.kind, got.accepted);
            failures++;
         end else begin
            want = expected_answers.pop_front();
            compare_field("answer_kind", 32'(want.kind), 32'(got.kind));
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("parent_address", want.parent_address, got.parent_address);
            compare_field("granted_count", want.granted_count, got.granted_count);
            compare_field("direction_write", 32'(want.direction_write),
                          32'(got.direction_write));
            compare_field("registered_mask", 32'(want.registered_mask),
                          32'(got.registered_mask));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [7:0]  req_sector_byte;
   logic [1:0]  req_partition_index;
   logic [31:0] req_block_address;
   logic [31:0] req_transfer_count;
   logic        rsp_valid;
   logic        rsp_answer_kind;
   logic        rsp_accepted;
   logic [31:0] rsp_parent_address;
   logic [31:0] rsp_granted_count;
   logic        rsp_direction_write;
   logic [3:0]  rsp_registered_mask;

   scoreboard_type    sb = new();
   answer_fields_type seen_answer;
   int                idle_pct;

   mbr_partition_map_translate_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_sector_byte     (req_sector_byte),
      .req_partition_index (req_partition_index),
      .req_block_address   (req_block_address),
      .req_transfer_count  (req_transfer_count),
      .rsp_valid           (rsp_valid),
      .rsp_answer_kind     (rsp_answer_kind),
      .rsp_accepted        (rsp_accepted),
      .rsp_parent_address  (rsp_parent_address),
      .rsp_granted_count   (rsp_granted_count),
      .rsp_direction_write (rsp_direction_write),
      .rsp_registered_mask (rsp_registered_mask)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   // monitor: answers and accepted requests, sampled at the edge
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid !== 1'b0) begin
            seen_answer = '{rsp_answer_kind, rsp_accepted, rsp_parent_address,
                            rsp_granted_count, rsp_direction_write, rsp_registered_mask};
            sb.check_answer(seen_answer);
         end
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_opcode, req_sector_byte, req_partition_index,
                            req_block_address, req_transfer_count);
      end
   end

   // present one request and hold it until the block takes it
   task automatic send_request(input logic [1:0] op, input logic [7:0] data,
                               input logic [1:0] idx, input logic [31:0] lba,
                               input logic [31:0] cnt);
      start               <= 1'b1;
      req_opcode          <= op;
      req_sector_byte     <= data;
      req_partition_index <= idx;
      req_block_address   <= lba;
      req_transfer_count  <= cnt;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // random sender idle cycles, each cycle idle with the phase's chance
   task automatic maybe_gap();
      while ($urandom_range(0, 99) < idle_pct) begin
         start           <= 1'b0;
         req_opcode      <= 2'($urandom);
         req_sector_byte <= 8'($urandom);
         @(posedge clock);
      end
   endtask

   // hold off until every predicted answer has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // read or write request aimed at the bounds of the addressed slot
   task automatic send_access();
      logic [1:0]  idx;
      logic [1:0]  op;
      logic [31:0] len;
      logic [31:0] lba;
      logic [31:0] cnt;
      idx = 2'($urandom);
      op  = $urandom_range(0, 1) ? mbrpt_pkg::OP_WRITE : mbrpt_pkg::OP_READ;
      len = sb.slots[idx].length;
      lba = $urandom;
      cnt = $urandom;
      case ($urandom_range(0, 9))
         0, 1: begin
            if (len != 32'd0) begin
               lba = $urandom % len;
               cnt = 32'd1 + $urandom % (len - lba);
            end
         end
         // whole slot
         2: begin
            lba = 32'd0;
            cnt = len;
         end
         // last block
         3: begin
            lba = len - 32'd1;
            cnt = 32'd1;
         end
         // first block past the end
         4: begin
            lba = len;
            cnt = 32'd1;
         end
         // one block too many
         5: begin
            if (len != 32'd0) begin
               lba = $urandom % len;
               cnt = len - lba + 32'd1;
            end
         end
         6: cnt = 32'd0;
         7: cnt = 32'hFFFF_FFFF;
         default: ;
      endcase
      send_request(op, 8'($urandom), idx, lba, cnt);
   endtask

   task automatic run_accesses(input int n);
      repeat (n) begin
         maybe_gap();
         if ($urandom_range(0, 49) == 0)
            send_request(OP_UNUSED, 8'($urandom), 2'($urandom), $urandom, $urandom);
         send_access();
      end
   endtask

   // one full sector with random entries, interleaved with accesses
   task automatic run_sector(input bit sig_good, input bit force_qualify);
      logic [7:0]  image [mbrpt_pkg::SECTOR_BYTES];
      logic [7:0]  kind;
      logic [31:0] first;
      logic [31:0] len;
      int          base;
      foreach (image[i]) image[i] = 8'($urandom);
      for (int e = 0; e < mbrpt_pkg::SLOT_COUNT; e++) begin
         base = mbrpt_pkg::TABLE_OFFSET + 16 * e;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = mbrpt_pkg::TYPE_LBA;
            4, 5, 6:    kind = mbrpt_pkg::TYPE_CHS;
            default:    kind = 8'($urandom);
         endcase
         case ($urandom_range(0, 3))
            1:       first = {24'hFF_FFFF, 8'($urandom)};
            2:       first = $urandom_range(0, 4096);
            default: first = $urandom;
         endcase
         case ($urandom_range(0, 6))
            0:       len = 32'd0;
            1, 2:    len = $urandom_range(1, 64);
            4:       len = 32'hFFFF_FFFF;
            5:       len = $urandom_range(1, 4);
            default: len = $urandom;
         endcase
         if (force_qualify && e == 0) begin
            kind = mbrpt_pkg::TYPE_LBA;
            if (len == 32'd0) len = 32'd1;
         end
         image[base + 4] = kind;
         for (int k = 0; k < 4; k++) begin
            image[base + 8 + k]  = first[8 * k +: 8];
            image[base + 12 + k] = len[8 * k +: 8];
         end
      end
      // signature, possibly broken in either byte or both
      image[mbrpt_pkg::SIG_OFFSET] = mbrpt_pkg::SIG_FIRST;
      image[mbrpt_pkg::LAST_BYTE]  = mbrpt_pkg::SIG_SECOND;
      if (!sig_good) begin
         case ($urandom_range(0, 2))
            0: image[mbrpt_pkg::SIG_OFFSET] = mbrpt_pkg::SIG_FIRST ^ 8'($urandom_range(1, 255));
            1: image[mbrpt_pkg::LAST_BYTE]  = mbrpt_pkg::SIG_SECOND ^ 8'($urandom_range(1, 255));
            default: begin
               image[mbrpt_pkg::SIG_OFFSET] = mbrpt_pkg::SIG_FIRST ^ 8'($urandom_range(1, 255));
               image[mbrpt_pkg::LAST_BYTE]  = mbrpt_pkg::SIG_SECOND ^ 8'($urandom_range(1, 255));
            end
         endcase
      end
      foreach (image[i]) begin
         maybe_gap();
         if ($urandom_range(0, 99) < 3) send_access();
         if ($urandom_range(0, 99) == 0)
            send_request(OP_UNUSED, 8'($urandom), 2'($urandom), $urandom, $urandom);
         send_request(mbrpt_pkg::OP_SECTOR, image[i], 2'($urandom), $urandom, $urandom);
      end
   endtask

   // stimulus
   initial begin
      reset               <= 1'b1;
      start               <= 1'b0;
      req_opcode          <= mbrpt_pkg::OP_SECTOR;
      req_sector_byte     <= '0;
      req_partition_index <= '0;
      req_block_address   <= '0;
      req_transfer_count  <= '0;
      idle_pct             = 32;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: every slot still invalid, field extremes, dropped opcode
      for (int i = 0; i < mbrpt_pkg::SLOT_COUNT; i++) begin
         send_request(mbrpt_pkg::OP_READ, 8'h00, 2'(i), 32'h0, 32'h1);
         send_request(mbrpt_pkg::OP_WRITE, 8'hFF, 2'(i), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end
      send_request(mbrpt_pkg::OP_READ, 8'hA5, 2'd3, 32'h0, 32'h0);
      send_request(OP_UNUSED, 8'hFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_UNUSED, 8'h00, 2'd0, 32'h0, 32'h0);
      wait_drained();

      // phase one: light sender gaps, good signature
      run_sector(1'b1, 1'b1);
      run_accesses(10);
      wait_drained();

      // phase two: heavy sender gaps, broken signature keeps the earlier table
      idle_pct = 81;
      run_sector(1'b0, 1'b0);
      run_accesses(10);
      wait_drained();

      // phase three: back to back accesses against the table
      idle_pct = 0;
      run_accesses(30);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d sector scans (%0d with a good signature) and %0d accesses",
               sb.scans, sb.good_scans, sb.accesses);
      $display("%0d accesses granted, %0d refused, %0d mismatches",
               sb.granted, sb.accesses - sb.granted, sb.failures);
      if (sb.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mbrpt_pkg.sv
rtl/core/mbrpt_sector_scan.sv
rtl/core/mbrpt_access_check.sv
rtl/core/mbr_partition_map_translate_unit.sv
bench/tb_mbr_partition_map_translate_unit.sv
